// ===== hw/rtl/dap_pkg.sv =====
`timescale 1ns / 1ps

package dap_pkg;

  localparam int AMOUNT_W        = 63;
  localparam int FRACTION_DIGITS = 8;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_DIGIT,
    KIND_DOT,
    KIND_MINUS,
    KIND_PLUS,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       first;
    logic       mode;
    logic       last;
  } token_t;

endpackage

// ===== hw/rtl/decimal_amount_parser.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  character[7:0], divisible, last
// out      out_valid/ out_stall amount[62:0]
//
// One character per cycle enters unless in_stall; the back end takes one queued
// character a cycle unless padding or a finished result is held by out_stall.
// A divisible string ending with k < FRACTION_DIGITS fraction digits gets
// FRACTION_DIGITS - k zero digits appended, one digit a cycle unless held.
// rst is synchronous; queue pointers and count, string state and out_valid clear.
// in_stall rises only when the four-entry queue is full.
module decimal_amount_parser #(
  parameter int FRACTION_DIGITS = dap_pkg::FRACTION_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   character,
  input  logic                         divisible,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dap_pkg::AMOUNT_W-1:0] amount
);
  import dap_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   tok_valid;
  token_t wr_token;
  token_t rd_token;

  dap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .divisible (divisible),
    .last      (last),
    .push      (push),
    .token     (wr_token),
    .full      (full)
  );

  dap_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_token (wr_token),
    .full     (full),
    .pop      (pop),
    .rd_valid (tok_valid),
    .rd_token (rd_token)
  );

  dap_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (rd_token),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .amount    (amount)
  );

endmodule

// ===== hw/rtl/dap_front.sv =====
`timescale 1ns / 1ps

module dap_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      character,
  input  logic            divisible,
  input  logic            last,
  output logic            push,
  output dap_pkg::token_t token,
  input  logic            full
);
  import dap_pkg::*;

  logic  at_first;
  logic  mode;
  kind_t kind;

  always_comb begin
    if (character == CHAR_MINUS) begin
      kind = KIND_MINUS;
    end else if (character == CHAR_PLUS) begin
      kind = KIND_PLUS;
    end else if (character == CHAR_DOT) begin
      kind = KIND_DOT;
    end else if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
      kind = KIND_DIGIT;
    end else begin
      kind = KIND_OTHER;
    end
  end

  assign in_stall    = full;
  assign push        = in_valid && !full;
  assign token.kind  = kind;
  assign token.digit = character[3:0];
  assign token.first = at_first;
  assign token.mode  = at_first ? divisible : mode;
  assign token.last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first <= 1'b1;
      mode     <= 1'b0;
    end else if (push) begin
      at_first <= last;
      mode     <= token.mode;
    end
  end

endmodule

// ===== hw/rtl/dap_queue.sv =====
`timescale 1ns / 1ps

module dap_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dap_pkg::token_t wr_token,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output dap_pkg::token_t rd_token
);
  import dap_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_token = mem[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dap_back.sv =====
`timescale 1ns / 1ps

module dap_back #(
  parameter int FRACTION_DIGITS = dap_pkg::FRACTION_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tok_valid,
  input  dap_pkg::token_t              tok,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dap_pkg::AMOUNT_W-1:0] amount
);
  import dap_pkg::*;

  localparam int FC_W   = $clog2(FRACTION_DIGITS + 1);
  localparam int WIDE_W = AMOUNT_W + 4;

  logic [AMOUNT_W-1:0] acc;
  logic                ovf;
  logic                failed;
  logic                after_dot;
  logic [FC_W-1:0]     fc;
  logic                pad;

  logic [AMOUNT_W-1:0] acc_next;
  logic                ovf_next;
  logic                failed_next;
  logic                after_dot_next;
  logic [FC_W-1:0]     fc_next;
  logic                pad_next;
  logic                emit;
  logic                out_free;

  logic                clear;
  logic [AMOUNT_W-1:0] b_acc;
  logic                b_ovf;
  logic                b_failed;
  logic                b_dot;
  logic [FC_W-1:0]     b_fc;
  logic [3:0]          push_d;
  logic [WIDE_W-1:0]   wide;
  logic [AMOUNT_W-1:0] p_acc;
  logic                p_ovf;

  assign out_free = !out_valid || !out_stall;
  assign clear    = !pad && tok_valid && tok.first;
  assign b_acc    = clear ? '0 : acc;
  assign b_ovf    = clear ? 1'b0 : ovf;
  assign b_failed = clear ? 1'b0 : failed;
  assign b_dot    = clear ? 1'b0 : after_dot;
  assign b_fc     = clear ? '0 : fc;
  assign push_d   = pad ? 4'd0 : tok.digit;

  assign wide = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1) + WIDE_W'(push_d);

  always_comb begin
    if (b_ovf) begin
      p_acc = b_acc;
      p_ovf = 1'b1;
    end else if (wide[WIDE_W-1:AMOUNT_W] != '0) begin
      p_acc = b_acc;
      p_ovf = 1'b1;
    end else begin
      p_acc = wide[AMOUNT_W-1:0];
      p_ovf = 1'b0;
    end
  end

  always_comb begin
    acc_next       = b_acc;
    ovf_next       = b_ovf;
    failed_next    = b_failed;
    after_dot_next = b_dot;
    fc_next        = b_fc;
    pad_next       = pad;
    pop            = 1'b0;
    emit           = 1'b0;
    if (pad) begin
      acc_next = p_acc;
      ovf_next = p_ovf;
      fc_next  = FC_W'(fc + 1'b1);
      if (fc_next == FC_W'(FRACTION_DIGITS)) begin
        pad_next = 1'b0;
        emit     = 1'b1;
      end
    end else if (tok_valid) begin
      case (tok.kind)
        KIND_MINUS: failed_next = 1'b1;
        default: begin
          if (!b_dot) begin
            if (tok.kind == KIND_DOT) begin
              after_dot_next = 1'b1;
            end else if (tok.kind == KIND_DIGIT) begin
              acc_next = p_acc;
              ovf_next = p_ovf;
            end else if (!(tok.first && tok.kind == KIND_PLUS)) begin
              failed_next = 1'b1;
            end
          end else if (tok.mode) begin
            if (tok.kind == KIND_DOT) begin
              failed_next = 1'b1;
            end else if (b_fc < FC_W'(FRACTION_DIGITS)) begin
              if (tok.kind == KIND_DIGIT) begin
                acc_next = p_acc;
                ovf_next = p_ovf;
              end else begin
                failed_next = 1'b1;
              end
              fc_next = FC_W'(b_fc + 1'b1);
            end
          end
        end
      endcase
      pop = 1'b1;
      if (tok.last) begin
        if (tok.mode && fc_next < FC_W'(FRACTION_DIGITS)) begin
          pad_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    end
    if (emit && !out_free) begin
      acc_next       = acc;
      ovf_next       = ovf;
      failed_next    = failed;
      after_dot_next = after_dot;
      fc_next        = fc;
      pad_next       = pad;
      pop            = 1'b0;
      emit           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      ovf       <= 1'b0;
      failed    <= 1'b0;
      after_dot <= 1'b0;
      fc        <= '0;
      pad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      ovf       <= ovf_next;
      failed    <= failed_next;
      after_dot <= after_dot_next;
      fc        <= fc_next;
      pad       <= pad_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      amount <= (failed_next || ovf_next) ? '0 : acc_next;
    end
  end

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= FC_W'(FRACTION_DIGITS))
    else $error("fraction count past limit");

  a_pad_no_pop: assert property (@(posedge clk) disable iff (rst)
    pad |-> !pop)
    else $error("token taken during zero padding");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(amount)))
    else $error("held result overwritten");

endmodule
